FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on rising clk, disabled in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

FILE: src/ois_pkg.sv
// Package of the ordered integer set: types, sizes and bit search functions.
`default_nettype none
package ois_pkg;
  localparam int unsigned KeyW = 16;
  localparam int unsigned CntW = 17;
  localparam int unsigned LeafDepth = 1024;
  localparam int unsigned LeafAw = 10;
  localparam int unsigned MidDepth = 16;
  localparam int unsigned MidAw = 4;

  typedef enum logic [2:0] {
    ActInsert = 3'd0,
    ActDelete = 3'd1,
    ActMember = 3'd2,
    ActSucc   = 3'd3,
    ActPred   = 3'd4,
    ActMin    = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    StIdle, StLeaf1, StMid1, StTop, StMid2, StLeaf2, StUpdLeaf, StUpdMid, StDone
  } state_e;

  typedef struct packed {
    logic       found;
    logic [5:0] pos;
  } find_t;

  // Lowest set bit.
  function automatic find_t find_low(input logic [63:0] m);
    find_t r;
    r.found = |m;
    r.pos = '0;
    for (int i = 63; i >= 0; i--) begin
      if (m[i]) r.pos = 6'(i);
    end
    return r;
  endfunction

  // Highest set bit.
  function automatic find_t find_high(input logic [63:0] m);
    find_t r;
    r.found = |m;
    r.pos = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) r.pos = 6'(i);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: src/ois_ram.sv
// Generic single port synchronous RAM with registered read.
`default_nettype none
module ois_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

FILE: src/ordered_integer_set_top.sv
// Top level of the ordered integer set: sequencer around two bitmap RAMs.
//
// Usage: drive action_i and key_i with start while busy is low; the beat
// is taken at that edge. Exactly one result beat follows on done_o with
// hit_o, result_key_o and element_count_o, valid for that one cycle only.
// Path by action: successor of the largest key, predecessor of key 0 and
// the unused action codes go straight to the result beat; a member test, a
// duplicate insert or an absent delete reads the leaf word only; an insert
// or delete that changes the set reads and writes the leaf word, then reads
// and writes the middle word; successor, predecessor and minimum follow the
// chain of dependent reads (leaf word, middle word, top word, middle word,
// leaf word) through the single port of each RAM.
// One item is in work at a time. busy is low again during the result beat,
// so the next command can be taken at the edge that takes the result.
// After reset a clearing pass zeroes the 1024 leaf words and 16 middle
// words, during which busy is high. The receiver cannot stall; results
// are never held.
`default_nettype none
module ordered_integer_set_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            action_i,
  input  wire logic [15:0]           key_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic [15:0]                result_key_o,
  output logic [16:0]                element_count_o
);
  import ois_pkg::*;

  state_e st_q, st_d;
  logic clr_q;
  logic [LeafAw:0] clr_cnt_q;
  logic [2:0] act_q;
  logic [KeyW-1:0] key_q, key_d;       // search position
  logic [15:0] top_q, top_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic hit_q, hit_d;
  logic [KeyW-1:0] res_q, res_d;
  logic dir_up_q, dir_up_d;
  logic [LeafAw-1:0] lw_q, lw_d;
  logic [MidAw-1:0] mw_q, mw_d;
  logic [63:0] lmask_q, lmask_d;
  logic done_q, done_d;

  logic leaf_we, mid_we;
  logic [LeafAw-1:0] leaf_addr;
  logic [MidAw-1:0] mid_addr;
  logic [63:0] leaf_wd, mid_wd, leaf_rd, mid_rd;

  ois_ram #(.Width(64), .Depth(LeafDepth)) u_leaf (
    .clk_i, .we_i(leaf_we), .addr_i(leaf_addr), .wdata_i(leaf_wd), .rdata_o(leaf_rd));
  ois_ram #(.Width(64), .Depth(MidDepth)) u_mid (
    .clk_i, .we_i(mid_we), .addr_i(mid_addr), .wdata_i(mid_wd), .rdata_o(mid_rd));

  logic [63:0] from_m, upto_m, mm, tm;
  find_t f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; clr_q <= 1'b1; clr_cnt_q <= '0; cnt_q <= '0;
      top_q <= '0; done_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; top_q <= top_d; done_q <= done_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == (LeafAw+1)'(LeafDepth - 1)) clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d; hit_q <= hit_d; res_q <= res_d; dir_up_q <= dir_up_d;
    lw_q <= lw_d; mw_q <= mw_d; lmask_q <= lmask_d;
    if (start && !busy) begin
      act_q <= action_i;
    end
  end

  assign busy = clr_q || (st_q != StIdle);
  assign done_o = done_q;
  assign hit_o = hit_q;
  assign result_key_o = res_q;
  assign element_count_o = cnt_q;

  always_comb begin
    st_d = st_q; key_d = key_q; top_d = top_q; cnt_d = cnt_q;
    hit_d = hit_q; res_d = res_q; dir_up_d = dir_up_q;
    lw_d = lw_q; mw_d = mw_q; lmask_d = lmask_q; done_d = 1'b0;
    leaf_we = 1'b0; mid_we = 1'b0;
    leaf_addr = key_q[15:6]; mid_addr = lw_q[9:6];
    leaf_wd = '0; mid_wd = '0;
    from_m = '0; upto_m = '0; mm = '0; tm = '0; f = '0;
    if (clr_q) begin
      leaf_we = 1'b1; leaf_addr = clr_cnt_q[LeafAw-1:0];
      mid_we = 1'b1; mid_addr = clr_cnt_q[MidAw-1:0];
    end else begin
      case (st_q)
        StIdle: begin
          if (start) begin
            hit_d = 1'b0; res_d = '0;
            case (action_i)
              ActInsert, ActDelete, ActMember: begin
                key_d = key_i; dir_up_d = 1'b1; st_d = StLeaf1;
              end
              ActSucc: begin
                if (key_i == 16'hFFFF) begin
                  st_d = StDone;
                end else begin
                  key_d = key_i + 16'd1; dir_up_d = 1'b1; st_d = StLeaf1;
                end
              end
              ActPred: begin
                if (key_i == '0) begin
                  st_d = StDone;
                end else begin
                  key_d = key_i - 16'd1; dir_up_d = 1'b0; st_d = StLeaf1;
                end
              end
              ActMin: begin
                key_d = '0; dir_up_d = 1'b1; st_d = StLeaf1;
              end
              default: st_d = StDone;
            endcase
            leaf_addr = key_d[15:6];
          end
        end
        StLeaf1: begin
          // Leaf word at the key has arrived.
          lw_d = key_q[15:6];
          lmask_d = leaf_rd;
          if (act_q == ActInsert || act_q == ActDelete || act_q == ActMember) begin
            hit_d = leaf_rd[key_q[5:0]];
            if (act_q == ActInsert && !hit_d) begin
              leaf_we = 1'b1; leaf_addr = key_q[15:6];
              leaf_wd = leaf_rd | (64'd1 << key_q[5:0]);
              lmask_d = leaf_wd; cnt_d = cnt_q + 1'b1;
              mid_addr = key_q[15:12]; st_d = StUpdMid;
            end else if (act_q == ActDelete && hit_d) begin
              leaf_we = 1'b1; leaf_addr = key_q[15:6];
              leaf_wd = leaf_rd & ~(64'd1 << key_q[5:0]);
              lmask_d = leaf_wd; cnt_d = cnt_q - 1'b1;
              mid_addr = key_q[15:12]; st_d = StUpdMid;
            end else begin
              st_d = StDone;
            end
          end else begin
            from_m = {64{1'b1}} << key_q[5:0];
            upto_m = {64{1'b1}} >> (6'd63 - key_q[5:0]);
            if (dir_up_q) f = find_low(leaf_rd & from_m);
            else f = find_high(leaf_rd & upto_m);
            if (f.found) begin
              hit_d = 1'b1; res_d = {key_q[15:6], f.pos}; st_d = StDone;
            end else if (dir_up_q ? (key_q[15:6] == '1) : (key_q[15:6] == '0)) begin
              st_d = StDone;
            end else begin
              lw_d = dir_up_q ? key_q[15:6] + 1'b1 : key_q[15:6] - 1'b1;
              mid_addr = lw_d[9:6]; st_d = StMid1;
            end
          end
        end
        StUpdMid: begin
          // Middle word of the changed leaf has arrived.
          mm = mid_rd;
          if (act_q == ActInsert) mm[lw_q[5:0]] = 1'b1;
          else if (lmask_q == '0) mm[lw_q[5:0]] = 1'b0;
          mid_we = 1'b1; mid_addr = lw_q[9:6]; mid_wd = mm;
          top_d[lw_q[9:6]] = |mm;
          st_d = StDone;
        end
        StMid1: begin
          from_m = {64{1'b1}} << lw_q[5:0];
          upto_m = {64{1'b1}} >> (6'd63 - lw_q[5:0]);
          if (dir_up_q) f = find_low(mid_rd & from_m);
          else f = find_high(mid_rd & upto_m);
          if (f.found) begin
            lw_d = {lw_q[9:6], f.pos}; leaf_addr = lw_d; st_d = StLeaf2;
          end else begin
            tm = {48'd0, top_q};
            from_m = {64{1'b1}} << ({2'b0, lw_q[9:6]} + 6'd1);
            upto_m = (lw_q[9:6] == '0) ? '0 :
                     {64{1'b1}} >> (7'd64 - {3'b0, lw_q[9:6]});
            if (dir_up_q) f = find_low(lw_q[9:6] == 4'hF ? '0 : (tm & from_m));
            else f = find_high(tm & upto_m);
            if (f.found) begin
              mw_d = f.pos[3:0]; mid_addr = mw_d; st_d = StMid2;
            end else begin
              st_d = StDone;
            end
          end
        end
        StMid2: begin
          if (dir_up_q) f = find_low(mid_rd);
          else f = find_high(mid_rd);
          lw_d = {mw_q, f.pos}; leaf_addr = lw_d; st_d = StLeaf2;
        end
        StLeaf2: begin
          if (dir_up_q) f = find_low(leaf_rd);
          else f = find_high(leaf_rd);
          hit_d = 1'b1; res_d = {lw_q, f.pos}; st_d = StDone;
        end
        StDone: begin
          done_d = 1'b1; st_d = StIdle;
        end
        default: st_d = StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/ois_checker.sv
// Port level checker of the ordered integer set and its bind.
`default_nettype none
`include "assert_macros.svh"
module ois_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic        hit_o,
  input wire logic [15:0] result_key_o,
  input wire logic [16:0] element_count_o
);
  `ASSERT_CLK(a_start_busy, clk_i, rst_ni, start && !busy |=> busy, "accepted beat did not raise busy")
  `ASSERT_CLK(a_done_busy, clk_i, rst_ni, done_o |-> !$past(done_o), "result beat lasted two cycles")
  `ASSERT_CLK(a_cnt_step, clk_i, rst_ni, !done_o |=> $stable(element_count_o) || $past(busy), "count moved while idle")
  `ASSERT_CLK(a_miss_zero, clk_i, rst_ni, done_o && !hit_o |-> result_key_o == 16'd0, "miss key")
endmodule
bind ordered_integer_set_top ois_checker u_ois_checker (.*);
`default_nettype wire
